/* rtl/ibpm_pkg.sv */
package ibpm_pkg;

  // result field widths
  localparam int unsigned StatusW = 2;
  localparam int unsigned DepthW  = 3;
  localparam int unsigned TopW    = 4;
  localparam int unsigned OffW    = 13;
  localparam int unsigned ResultW = StatusW + DepthW + TopW + 3 * OffW;

  // register map, indexed by paddr[4:3]
  localparam logic [1:0] REG_FS_VERSION  = 2'd0;
  localparam logic [1:0] REG_BLOCK_SHIFT = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES   = 2'd2;

  localparam logic        FS_VERSION_RST  = 1'b0;
  localparam logic [3:0]  BLOCK_SHIFT_RST = 4'd10;
  localparam logic [62:0] MAX_BYTES_RST   = 63'd268966912;

  // layout constants
  localparam logic [3:0] DIRECT_SLOTS    = 4'd7;
  localparam logic [3:0] V1_ENTRY_SHIFT  = 4'd9;
  localparam logic [3:0] V1_BYTE_SHIFT   = 4'd10;
  localparam logic [3:0] MIN_BLOCK_SHIFT = 4'd10;

  typedef enum logic [StatusW-1:0] {
    STATUS_MAPPED   = 2'd0,
    STATUS_NEGATIVE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [OffW-1:0]   level3_offset;
    logic [OffW-1:0]   level2_offset;
    logic [OffW-1:0]   level1_offset;
    logic [TopW-1:0]   top_offset;
    logic [DepthW-1:0] path_depth;
    status_e           status;
  } result_t;

endpackage

/* rtl/ibpm_map.sv */
module ibpm_map #(
  parameter int unsigned INDEX_BITS      = 40,
  parameter int unsigned MAX_BLOCK_SHIFT = 15
) (
  input  logic [INDEX_BITS-1:0] block_index_i,
  input  logic                  fs_version_i,
  input  logic [3:0]            block_shift_i,
  input  logic [62:0]           max_bytes_i,
  output ibpm_pkg::result_t     result_o
);

  localparam int unsigned IdxW   = INDEX_BITS - 1;
  localparam int unsigned EsMax  = MAX_BLOCK_SHIFT - 2;
  localparam int unsigned TreeW  = (INDEX_BITS > 3 * EsMax + 2) ? INDEX_BITS : 3 * EsMax + 2;
  localparam int unsigned LimW   = (IdxW + MAX_BLOCK_SHIFT > 63) ? IdxW + MAX_BLOCK_SHIFT : 63;
  localparam logic [4:0]  MaxShW = 5'(MAX_BLOCK_SHIFT);
  localparam int unsigned OffW   = ibpm_pkg::OffW;

  logic              negative;
  logic [IdxW-1:0]   idx;
  logic [3:0]        bs_clamped;
  logic [3:0]        es;
  logic [3:0]        byte_shift;
  logic [4:0]        es2;
  logic [5:0]        es3;
  logic [LimW-1:0]   scaled;
  logic              over_limit;
  logic [TreeW-1:0]  idx_t;
  logic [TreeW-1:0]  ent;
  logic [TreeW-1:0]  em;
  logic [TreeW-1:0]  bound2;
  logic [TreeW-1:0]  bound3;
  logic [TreeW-1:0]  bound4;
  logic              in_direct;
  logic              in_single;
  logic              in_double;
  logic              in_triple;
  logic [TreeW-1:0]  base;
  logic [TreeW-1:0]  rel;
  logic [TreeW-1:0]  rel_s1;
  logic [TreeW-1:0]  rel_s2;

  always_comb begin
    negative = block_index_i[INDEX_BITS-1];
    idx      = block_index_i[IdxW-1:0];

    bs_clamped = block_shift_i;
    if (block_shift_i < ibpm_pkg::MIN_BLOCK_SHIFT) begin
      bs_clamped = ibpm_pkg::MIN_BLOCK_SHIFT;
    end else if ({1'b0, block_shift_i} > MaxShW) begin
      bs_clamped = MaxShW[3:0];
    end

    if (fs_version_i) begin
      es         = bs_clamped - 4'd2;
      byte_shift = bs_clamped;
    end else begin
      es         = ibpm_pkg::V1_ENTRY_SHIFT;
      byte_shift = ibpm_pkg::V1_BYTE_SHIFT;
    end
    es2 = {es, 1'b0};
    es3 = {2'b00, es} + {1'b0, es, 1'b0};

    // index * block size >= max_bytes, exact in a widened compare
    scaled     = LimW'(idx) << byte_shift;
    over_limit = scaled >= LimW'(max_bytes_i);

    // region sizes are distinct powers of two above the direct slots, so the
    // running sums are plain ors
    idx_t  = TreeW'(idx);
    ent    = TreeW'(1) << es;
    em     = ent - TreeW'(1);
    bound2 = ent | TreeW'(ibpm_pkg::DIRECT_SLOTS);
    bound3 = bound2 | (TreeW'(1) << es2);
    bound4 = bound3 | (TreeW'(1) << es3);

    in_direct = idx_t < TreeW'(ibpm_pkg::DIRECT_SLOTS);
    in_single = idx_t < bound2;
    in_double = idx_t < bound3;
    in_triple = fs_version_i && (idx_t < bound4);

    if (in_single) begin
      base = TreeW'(ibpm_pkg::DIRECT_SLOTS);
    end else if (in_double) begin
      base = bound2;
    end else begin
      base = bound3;
    end
    rel    = idx_t - base;
    rel_s1 = rel >> es;
    rel_s2 = rel >> es2;

    result_o = '0;
    if (negative) begin
      result_o.status = ibpm_pkg::STATUS_NEGATIVE;
    end else if (over_limit) begin
      result_o.status = ibpm_pkg::STATUS_RANGE;
    end else if (in_direct) begin
      result_o.status     = ibpm_pkg::STATUS_MAPPED;
      result_o.path_depth = 3'd1;
      result_o.top_offset = idx_t[3:0];
    end else if (in_single) begin
      result_o.status        = ibpm_pkg::STATUS_MAPPED;
      result_o.path_depth    = 3'd2;
      result_o.top_offset    = ibpm_pkg::DIRECT_SLOTS;
      result_o.level1_offset = rel[OffW-1:0];
    end else if (in_double) begin
      result_o.status        = ibpm_pkg::STATUS_MAPPED;
      result_o.path_depth    = 3'd3;
      result_o.top_offset    = ibpm_pkg::DIRECT_SLOTS + 4'd1;
      result_o.level1_offset = rel_s1[OffW-1:0];
      result_o.level2_offset = rel[OffW-1:0] & em[OffW-1:0];
    end else if (in_triple) begin
      result_o.status        = ibpm_pkg::STATUS_MAPPED;
      result_o.path_depth    = 3'd4;
      result_o.top_offset    = ibpm_pkg::DIRECT_SLOTS + 4'd2;
      result_o.level1_offset = rel_s2[OffW-1:0];
      result_o.level2_offset = rel_s1[OffW-1:0] & em[OffW-1:0];
      result_o.level3_offset = rel[OffW-1:0] & em[OffW-1:0];
    end else begin
      result_o.status = ibpm_pkg::STATUS_RANGE;
    end
  end

endmodule

/* rtl/inode_block_path_mapper.sv */
// Maps a logical file block index to its inode pointer path (depth 1 to 4,
// slot and per-level offsets). One index is taken per clock cycle when the
// output side keeps up. An accepted index is held in the input register
// while the mapping logic feeds the result register, from which the result
// is offered once that register is free. While a result waits, a second
// index is held in the input register and tready drops only then.
// Configuration lives behind the APB port at byte addresses 0x00
// (fs_version), 0x08 (block_shift, log2 of the block size) and 0x10
// (max_bytes) and must only be changed while no index is in flight.
module inode_block_path_mapper #(
  parameter int unsigned MAX_BLOCK_SHIFT = 15,
  parameter int unsigned INDEX_BITS      = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [INDEX_BITS-1:0] block_index, rest zero padding
  input  logic [((INDEX_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [4:2] path_depth, [8:5] top_offset, [21:9] level1_offset,
  // [34:22] level2_offset, [47:35] level3_offset
  output logic [ibpm_pkg::ResultW-1:0]        m_axis_tdata,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready
);

  logic                    fs_version_q;
  logic [3:0]              block_shift_q;
  logic [62:0]             max_bytes_q;
  logic                    cfg_write;

  logic                    in_valid_q;
  logic [INDEX_BITS-1:0]   in_index_q;
  logic                    out_valid_q;
  ibpm_pkg::result_t       out_result_q;
  ibpm_pkg::result_t       result_d;
  logic                    out_ready;
  logic                    advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_version_q  <= ibpm_pkg::FS_VERSION_RST;
      block_shift_q <= ibpm_pkg::BLOCK_SHIFT_RST;
      max_bytes_q   <= ibpm_pkg::MAX_BYTES_RST;
    end else if (cfg_write) begin
      case (paddr[4:3])
        ibpm_pkg::REG_FS_VERSION:  fs_version_q  <= pwdata[0];
        ibpm_pkg::REG_BLOCK_SHIFT: block_shift_q <= pwdata[3:0];
        ibpm_pkg::REG_MAX_BYTES:   max_bytes_q   <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      ibpm_pkg::REG_FS_VERSION:  prdata = {63'd0, fs_version_q};
      ibpm_pkg::REG_BLOCK_SHIFT: prdata = {60'd0, block_shift_q};
      ibpm_pkg::REG_MAX_BYTES:   prdata = {1'b0, max_bytes_q};
      default:                   prdata = '0;
    endcase
  end

  // result register frees when empty or when its transfer completes
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_index_q <= s_axis_tdata[INDEX_BITS-1:0];
    end
    if (advance) begin
      out_result_q <= result_d;
    end
  end

  ibpm_map #(
    .INDEX_BITS      (INDEX_BITS),
    .MAX_BLOCK_SHIFT (MAX_BLOCK_SHIFT)
  ) u_map (
    .block_index_i (in_index_q),
    .fs_version_i  (fs_version_q),
    .block_shift_i (block_shift_q),
    .max_bytes_i   (max_bytes_q),
    .result_o      (result_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_result_q;

endmodule
